>>> rtl/pdpc_pkg.sv
package pdpc_pkg;

  // Field and register widths
  localparam int DIR_W      = 2;
  localparam int TARGET_W   = 20;
  localparam int MAXV_W     = 10;
  localparam int GAIN_W     = 24;
  localparam int ZONE_W     = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int VEL_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Default values of the module parameters
  localparam int MIN_VELOCITY_DEF   = 20;
  localparam int INTEGRAL_CAP_DEF   = 20;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int POS_BITS_DEF       = 24;

  // Register reset values
  localparam logic [TARGET_W-1:0]  TARGET_RST  = '0;
  localparam logic [MAXV_W-1:0]    MAXV_RST    = MAXV_W'(200);
  localparam logic [GAIN_W-1:0]    GAIN_P_RST  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]    GAIN_I_RST  = GAIN_W'(7);
  localparam logic [GAIN_W-1:0]    GAIN_D_RST  = GAIN_W'(13107);
  localparam logic [ZONE_W-1:0]    ZONE_RST    = ZONE_W'(156);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(250);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION = 3'd0,
    REG_TARGET    = 3'd1,
    REG_MAX_VEL   = 3'd2,
    REG_GAIN_P    = 3'd3,
    REG_GAIN_I    = 3'd4,
    REG_GAIN_D    = 3'd5,
    REG_ZONE      = 3'd6,
    REG_TIMEOUT   = 3'd7
  } cfg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_LEFT     = 2'd2,
    DIR_RIGHT    = 2'd3
  } dir_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE    = 2'd0,
    ST_RUN     = 2'd1,
    ST_PASSED  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // Settings that shape the final velocity pair
  typedef struct packed {
    dir_t              dir;
    logic [MAXV_W-1:0] max_vel;
  } shape_cfg_t;

endpackage

>>> rtl/pdpc_shaper.sv
module pdpc_shaper #(
  parameter int SUM_W          = 48,
  parameter int GAIN_FRAC_BITS = pdpc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int MIN_VELOCITY   = pdpc_pkg::MIN_VELOCITY_DEF
) (
  input  logic signed [SUM_W-1:0]           sum,
  input  pdpc_pkg::status_t                 st,
  input  pdpc_pkg::shape_cfg_t              cfg,
  output logic signed [pdpc_pkg::VEL_W-1:0] left_vel,
  output logic signed [pdpc_pkg::VEL_W-1:0] right_vel
);
  import pdpc_pkg::*;

  logic [SUM_W-1:0]       mag;
  logic [SUM_W-1:0]       mag_int;
  logic signed [VEL_W-1:0] vel;

  // Truncate towards zero: shift the magnitude, then restore the sign.
  assign mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag_int = mag >> GAIN_FRAC_BITS;

  // The upper clamp wins and drops the sign; the lower clamp is positive too.
  always_comb begin
    if (mag_int > SUM_W'(cfg.max_vel)) begin
      vel = VEL_W'(cfg.max_vel);
    end else if (mag_int < SUM_W'(MIN_VELOCITY)) begin
      vel = VEL_W'(MIN_VELOCITY);
    end else if (sum[SUM_W-1]) begin
      vel = -$signed(mag_int[VEL_W-1:0]);
    end else begin
      vel = $signed(mag_int[VEL_W-1:0]);
    end
  end

  // Wheel signs follow the direction mode; anything but a running tick is zero.
  always_comb begin
    left_vel  = '0;
    right_vel = '0;
    if (st == ST_RUN) begin
      unique case (cfg.dir)
        DIR_FORWARD: begin
          left_vel  = vel;
          right_vel = vel;
        end
        DIR_BACKWARD: begin
          left_vel  = -vel;
          right_vel = -vel;
        end
        DIR_LEFT: begin
          left_vel  = -vel;
          right_vel = vel;
        end
        DIR_RIGHT: begin
          left_vel  = vel;
          right_vel = -vel;
        end
      endcase
    end
  end

endmodule

>>> rtl/pid_drive_position_controller_top.sv
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  ---------------------------------------------
// in        input      in_valid / in_stall  start_req and four encoder positions
// out       output     out_valid/out_stall  left_velocity, right_velocity, status
// cfg       input      cfg_write            cfg_index, cfg_data (no handshake back)
//
// One word is accepted every cycle while in_stall is low; results leave from the output register.
// The single stage 5 step that updates active, integral, last error and tick count sets that rate.
// rst is synchronous: it empties the pipeline, clears controller state and loads register defaults.
// A stalled output freezes only the stages behind it that are full; empty stages keep filling.
module pid_drive_position_controller_top #(
  parameter int POS_BITS       = pdpc_pkg::POS_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pdpc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int MIN_VELOCITY   = pdpc_pkg::MIN_VELOCITY_DEF,
  parameter int INTEGRAL_CAP   = pdpc_pkg::INTEGRAL_CAP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port
  input  logic                                  cfg_write,
  input  logic [pdpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pdpc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  start_req,
  input  logic signed [POS_BITS-1:0]            left_front_pos,
  input  logic signed [POS_BITS-1:0]            left_back_pos,
  input  logic signed [POS_BITS-1:0]            right_front_pos,
  input  logic signed [POS_BITS-1:0]            right_back_pos,
  // Output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pdpc_pkg::VEL_W-1:0]     left_velocity,
  output logic signed [pdpc_pkg::VEL_W-1:0]     right_velocity,
  output logic [pdpc_pkg::STATUS_W-1:0]         status
);
  import pdpc_pkg::*;

  localparam int PROG_W  = POS_BITS + 1;
  localparam int ERR_W   = ((PROG_W > TARGET_W) ? PROG_W : TARGET_W) + 1;
  localparam int EMAG_W  = TARGET_W;
  localparam int PROD_W  = GAIN_W + EMAG_W;
  localparam int DIFF_W  = EMAG_W + 1;
  localparam int DPROD_W = GAIN_W + 1 + DIFF_W;
  localparam int ITMP_W  = PROD_W + 2;
  localparam int ACC_W   = $clog2(INTEGRAL_CAP + 1) + GAIN_FRAC_BITS + 1;
  localparam int SUM_W   = DPROD_W + 2;
  localparam longint CAP_Q = longint'(INTEGRAL_CAP) << GAIN_FRAC_BITS;
  localparam logic signed [ITMP_W-1:0] CAP_POS = ITMP_W'(CAP_Q);
  localparam logic signed [ITMP_W-1:0] CAP_NEG = -CAP_POS;
  localparam logic signed [ACC_W-1:0]  ACC_POS = ACC_W'(CAP_Q);
  localparam logic signed [ACC_W-1:0]  ACC_NEG = -ACC_POS;

  // Configuration registers
  dir_t                 direction_mode;
  logic [TARGET_W-1:0]  target_ticks;
  logic [MAXV_W-1:0]    max_velocity;
  logic [GAIN_W-1:0]    gain_p;
  logic [GAIN_W-1:0]    gain_i;
  logic [GAIN_W-1:0]    gain_d;
  logic [ZONE_W-1:0]    integral_zone;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mode <= DIR_FORWARD;
      target_ticks   <= TARGET_RST;
      max_velocity   <= MAXV_RST;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      integral_zone  <= ZONE_RST;
      timeout_ticks  <= TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DIRECTION: direction_mode <= dir_t'(cfg_data[DIR_W-1:0]);
        REG_TARGET:    target_ticks   <= cfg_data[TARGET_W-1:0];
        REG_MAX_VEL:   max_velocity   <= cfg_data[MAXV_W-1:0];
        REG_GAIN_P:    gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= cfg_data[GAIN_W-1:0];
        REG_ZONE:      integral_zone  <= cfg_data[ZONE_W-1:0];
        REG_TIMEOUT:   timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
      endcase
    end
  end

  // Stage valids and advance chain; stage 7 is the output register.
  logic [7:1] vld;
  logic [7:1] adv;

  always_comb begin
    adv[7] = !vld[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: input register.
  logic                       s1_start;
  logic signed [POS_BITS-1:0] s1_lf, s1_lb, s1_rf, s1_rb;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_start <= start_req;
      s1_lf    <= left_front_pos;
      s1_lb    <= left_back_pos;
      s1_rf    <= right_front_pos;
      s1_rb    <= right_back_pos;
    end
  end

  // Stage 2: half of the absolute pair sum on each side.
  logic signed [POS_BITS:0] lsum, rsum;
  logic [POS_BITS:0]        labs, rabs;
  logic                     s2_start;
  logic [POS_BITS-1:0]      s2_lhalf, s2_rhalf;

  assign lsum = (POS_BITS + 1)'(s1_lf) + (POS_BITS + 1)'(s1_lb);
  assign rsum = (POS_BITS + 1)'(s1_rf) + (POS_BITS + 1)'(s1_rb);
  assign labs = lsum[POS_BITS] ? (POS_BITS + 1)'(-lsum) : (POS_BITS + 1)'(lsum);
  assign rabs = rsum[POS_BITS] ? (POS_BITS + 1)'(-rsum) : (POS_BITS + 1)'(rsum);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_start <= s1_start;
      s2_lhalf <= labs[POS_BITS:1];
      s2_rhalf <= rabs[POS_BITS:1];
    end
  end

  // Stage 3: progress and error against the target.
  logic [PROG_W-1:0]       progress;
  logic signed [ERR_W-1:0] err;
  logic                    s3_start;
  logic                    s3_neg;
  logic [EMAG_W-1:0]       s3_emag;

  assign progress = PROG_W'(s2_lhalf) + PROG_W'(s2_rhalf);
  assign err      = $signed(ERR_W'(target_ticks)) - $signed(ERR_W'(progress));

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_start <= s2_start;
      s3_neg   <= err[ERR_W-1];
      s3_emag  <= err[EMAG_W-1:0];
    end
  end

  // Stage 4: proportional and integral products, zone test.
  logic              s4_start;
  logic              s4_neg;
  logic              s4_zero;
  logic              s4_in_zone;
  logic [EMAG_W-1:0] s4_emag;
  logic [PROD_W-1:0] s4_pprod;
  logic [PROD_W-1:0] s4_iprod;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_start   <= s3_start;
      s4_neg     <= s3_neg;
      s4_zero    <= (s3_emag == '0);
      s4_in_zone <= (s3_emag != '0) && (s3_emag < EMAG_W'(integral_zone));
      s4_emag    <= s3_emag;
      s4_pprod   <= gain_p * s3_emag;
      s4_iprod   <= gain_i * s3_emag;
    end
  end

  // Stage 5: controller state. All carried values update here in one step.
  logic                    active;
  logic signed [ACC_W-1:0] integral_acc;
  logic [EMAG_W-1:0]       previous_error;
  logic [TIMEOUT_W-1:0]    tick_count;

  logic                     act_eff;
  logic signed [ACC_W-1:0]  acc_eff;
  logic [EMAG_W-1:0]        prev_eff;
  logic [TIMEOUT_W-1:0]     tick_eff;
  status_t                  st_next;
  logic signed [ITMP_W-1:0] acc_sum;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DPROD_W-1:0] dmul;
  logic signed [DPROD_W-1:0] dprod;
  logic                     load5;

  assign load5    = adv[5] && vld[4];
  assign act_eff  = s4_start || active;
  assign acc_eff  = s4_start ? '0 : integral_acc;
  assign prev_eff = s4_start ? '0 : previous_error;
  assign tick_eff = s4_start ? '0 : tick_count;

  always_comb begin
    priority if (!act_eff) begin
      st_next = ST_IDLE;
    end else if (tick_eff >= timeout_ticks) begin
      st_next = ST_TIMEOUT;
    end else if (s4_neg) begin
      st_next = ST_PASSED;
    end else begin
      st_next = ST_RUN;
    end
  end

  // Integral inside the zone, held within the cap on both sides.
  assign acc_sum = ITMP_W'(acc_eff) + $signed(ITMP_W'(s4_iprod));

  always_comb begin
    if (!s4_in_zone) begin
      acc_new = '0;
    end else if (acc_sum > CAP_POS) begin
      acc_new = ACC_POS;
    end else if (acc_sum < CAP_NEG) begin
      acc_new = ACC_NEG;
    end else begin
      acc_new = ACC_W'(acc_sum);
    end
  end

  // Derivative on the change of error, dropped at zero error.
  // The product is formed on its own so that it stays a signed multiply.
  assign diff  = $signed({1'b0, s4_emag}) - $signed({1'b0, prev_eff});
  assign dmul  = $signed({1'b0, gain_d}) * diff;
  assign dprod = s4_zero ? '0 : dmul;

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      integral_acc   <= '0;
      previous_error <= '0;
      tick_count     <= '0;
    end else if (load5) begin
      active         <= (st_next == ST_RUN);
      integral_acc   <= (st_next == ST_RUN) ? acc_new : acc_eff;
      previous_error <= (st_next == ST_RUN) ? s4_emag : prev_eff;
      tick_count     <= (st_next == ST_RUN) ? tick_eff + 1'b1 : tick_eff;
    end
  end

  status_t                   s5_status;
  logic [PROD_W-1:0]         s5_pprod;
  logic signed [ACC_W-1:0]   s5_iacc;
  logic signed [DPROD_W-1:0] s5_dprod;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_status <= st_next;
      s5_pprod  <= s4_pprod;
      s5_iacc   <= acc_new;
      s5_dprod  <= dprod;
    end
  end

  // Stage 6: sum of the three terms.
  status_t                 s6_status;
  logic signed [SUM_W-1:0] s6_sum;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_status <= s5_status;
      s6_sum    <= $signed(SUM_W'(s5_pprod)) + SUM_W'(s5_iacc) + SUM_W'(s5_dprod);
    end
  end

  // Stage 7: clamp, wheel signs and output register.
  shape_cfg_t              shape_cfg;
  logic signed [VEL_W-1:0] left_c, right_c;
  status_t                 s7_status;

  assign shape_cfg.dir     = direction_mode;
  assign shape_cfg.max_vel = max_velocity;

  pdpc_shaper #(
    .SUM_W          (SUM_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .MIN_VELOCITY   (MIN_VELOCITY)
  ) u_shaper (
    .sum       (s6_sum),
    .st        (s6_status),
    .cfg       (shape_cfg),
    .left_vel  (left_c),
    .right_vel (right_c)
  );

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_status      <= s6_status;
      left_velocity  <= left_c;
      right_velocity <= right_c;
    end
  end

  assign out_valid = vld[7];
  assign status    = s7_status;

  // An empty pipeline always takes a word.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    (vld == '0) |-> !in_stall)
    else $error("input stalled with an empty pipeline");

  // Only a running tick drives the wheels.
  a_stop_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (s7_status != ST_RUN)) |-> (left_velocity == '0 && right_velocity == '0))
    else $error("non-zero velocity on a stopped tick");

  // Driving forwards, both sides get the same command.
  a_forward_equal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && s7_status == ST_RUN && direction_mode == DIR_FORWARD)
      |-> (left_velocity == right_velocity))
    else $error("forward move with unequal wheel commands");

  // The stored integral stays inside the cap.
  a_integral_cap: assert property (@(posedge clk) disable iff (rst)
    (integral_acc <= ACC_POS) && (integral_acc >= ACC_NEG))
    else $error("integral outside its cap");

  // A stopped move leaves the controller inactive.
  a_stop_clears_active: assert property (@(posedge clk) disable iff (rst)
    (load5 && (st_next == ST_PASSED || st_next == ST_TIMEOUT)) |=> !active)
    else $error("controller still active after the move ended");

endmodule
